@@ sv/assert_macros.svh @@
// Assertion macros used by the look-at view matrix back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ sv/lav_pkg.sv @@
// Types and helpers shared by the look-at view matrix modules
package lav_pkg;
	localparam int unsigned QueueDepth = 2;

	typedef enum logic [3:0] {
		B_IDLE, B_PRE, B_SQ, B_SQRT, B_DIV, B_CROSS, B_V, B_OFF, B_EMIT
	} bst_t;

	typedef struct packed {
		logic [1:0] row;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bz;
		logic signed [31:0] offset;
		logic degenerate;
		logic last;
	} row_beat_t;

	typedef struct packed {
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] dz;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
		logic signed [31:0] ux;
		logic signed [31:0] uy;
		logic signed [31:0] uz;
		logic zero;
	} job_t;
endpackage

@@ sv/lav_front.sv @@
// Front end: accept items, form the look direction and flag zero vectors
module lav_front
	import lav_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic func,
	input logic signed [31:0] pos_x,
	input logic signed [31:0] pos_y,
	input logic signed [31:0] pos_z,
	input logic signed [31:0] look_x,
	input logic signed [31:0] look_y,
	input logic signed [31:0] look_z,
	input logic signed [31:0] up_x,
	input logic signed [31:0] up_y,
	input logic signed [31:0] up_z,
	output logic job_valid,
	input logic job_ready,
	output job_t job
);
	logic [1:0] cnt_q;
	job_t mem_q [QueueDepth];
	logic wp_q, rp_q;
	job_t nj;

	always_comb begin
		nj.px = pos_x; nj.py = pos_y; nj.pz = pos_z;
		nj.ux = up_x; nj.uy = up_y; nj.uz = up_z;
		nj.dx = 33'(look_x) - (func ? 33'(pos_x) : 33'sd0);
		nj.dy = 33'(look_y) - (func ? 33'(pos_y) : 33'sd0);
		nj.dz = 33'(look_z) - (func ? 33'(pos_z) : 33'sd0);
		nj.zero = (look_x == (func ? pos_x : 32'sd0)) && (look_y == (func ? pos_y : 32'sd0))
			&& (look_z == (func ? pos_z : 32'sd0))
			|| (up_x == 32'sd0 && up_y == 32'sd0 && up_z == 32'sd0);
	end

	assign in_ready = cnt_q != 2'(QueueDepth);
	assign job_valid = cnt_q != 2'd0;
	assign job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) mem_q[wp_q] <= nj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (job_valid && job_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(job_valid && job_ready);
		end
	end
endmodule

@@ sv/lav_back.sv @@
// Back end: sequencer that builds the basis and offsets with shared units
module lav_back
	import lav_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic job_valid,
	output logic job_ready,
	input job_t job,
	output logic out_valid,
	input logic out_ready,
	output row_beat_t beat
);
	bst_t st_q, st_d;

	logic pass_q; // 0 = w, 1 = u
	logic signed [63:0] a_q [3];
	logic signed [31:0] s_q [3];
	logic signed [31:0] w_q [3], u_q [3], v_q [3];
	logic signed [31:0] p_q [3], up_q [3];
	logic bad_q;
	logic [63:0] rem_q, res_q, bit_q;
	logic [31:0] n_q;
	logic [1:0] ci_q;
	logic [63:0] num_q, quo_q;
	logic [6:0] dstep_q;
	logic [1:0] orow_q;
	logic [1:0] oi_q;
	logic signed [95:0] acc_q;
	logic signed [31:0] off_q [3];
	logic [1:0] er_q;

	// prescale of a_q
	logic [63:0] m0, m1, m2, mx;
	logic [6:0] lz;
	logic signed [63:0] sh [3];
	function automatic logic [63:0] mg(input logic signed [63:0] x);
		mg = x[63] ? 64'(-x) : 64'(x);
	endfunction
	always_comb begin
		m0 = mg(a_q[0]); m1 = mg(a_q[1]); m2 = mg(a_q[2]);
		mx = m0 > m1 ? m0 : m1;
		mx = mx > m2 ? mx : m2;
		lz = 7'd64;
		for (int i = 0; i < 64; i++) if (mx[i]) lz = 7'(63 - i);
		for (int i = 0; i < 3; i++) begin
			if (lz < 7'd34) sh[i] = a_q[i] >>> (7'd34 - lz);
			else sh[i] = a_q[i] <<< (lz - 7'd34);
		end
	end

	// prescale of the up vector, taken once before the first cross product
	logic [63:0] um0, um1, um2, umx;
	logic [6:0] ulz;
	logic signed [63:0] ush [3];
	always_comb begin
		um0 = mg(64'(up_q[0])); um1 = mg(64'(up_q[1])); um2 = mg(64'(up_q[2]));
		umx = um0 > um1 ? um0 : um1;
		umx = umx > um2 ? umx : um2;
		ulz = 7'd64;
		for (int i = 0; i < 64; i++) if (umx[i]) ulz = 7'(63 - i);
		for (int i = 0; i < 3; i++) begin
			if (ulz < 7'd34) ush[i] = 64'(up_q[i]) >>> (7'd34 - ulz);
			else ush[i] = 64'(up_q[i]) <<< (ulz - 7'd34);
		end
	end

	logic [63:0] cur_mag, q_r;
	logic [1:0] ci_nx;
	always_comb begin
		cur_mag = mg(64'(s_q[ci_q]));
		q_r = quo_q > 64'(1 << 30) ? 64'(1 << 30) : quo_q;
		ci_nx = ci_q == 2'd2 ? 2'd0 : ci_q + 2'd1;
	end

	logic signed [63:0] sq [3];
	always_comb begin
		for (int i = 0; i < 3; i++) sq[i] = s_q[i] * s_q[i];
	end

	// one multiplier, used per cycle in the cross and offset steps
	logic signed [31:0] ma, mb;
	logic signed [63:0] mp;
	assign mp = ma * mb;

	logic [1:0] sel_q;
	logic signed [63:0] cr_q;
	always_comb begin
		ma = '0; mb = '0;
		case (st_q)
			B_CROSS, B_V: begin
				// term sel 0: a[i+1]*b[i+2], sel 1: a[i+2]*b[i+1]
				ma = w_q[sel_q[0] ? (ci_q == 2'd0 ? 2 : ci_q == 2'd1 ? 0 : 1)
					: (ci_q == 2'd0 ? 1 : ci_q == 2'd1 ? 2 : 0)];
				if (st_q == B_CROSS) mb = up_q[sel_q[0] ? (ci_q == 2'd0 ? 1 : ci_q == 2'd1 ? 2 : 0)
					: (ci_q == 2'd0 ? 2 : ci_q == 2'd1 ? 0 : 1)];
				else mb = u_q[sel_q[0] ? (ci_q == 2'd0 ? 1 : ci_q == 2'd1 ? 2 : 0)
					: (ci_q == 2'd0 ? 2 : ci_q == 2'd1 ? 0 : 1)];
			end
			B_OFF: begin
				ma = orow_q == 2'd0 ? u_q[oi_q] : orow_q == 2'd1 ? v_q[oi_q] : w_q[oi_q];
				mb = p_q[oi_q];
			end
			default: ;
		endcase
	end

	logic signed [95:0] rs;
	logic signed [63:0] rv;
	always_comb begin
		rs = (-acc_q + 96'sd536870912) >>> 30;
		rv = (cr_q - mp + 64'sd536870912) >>> 30;
	end

	assign job_ready = st_q == B_IDLE;
	assign out_valid = st_q == B_EMIT;
	always_comb begin
		beat.row = er_q;
		beat.last = er_q == 2'd2;
		beat.degenerate = bad_q;
		beat.bx = bad_q ? '0 : er_q == 2'd0 ? u_q[0] : er_q == 2'd1 ? v_q[0] : w_q[0];
		beat.by = bad_q ? '0 : er_q == 2'd0 ? u_q[1] : er_q == 2'd1 ? v_q[1] : w_q[1];
		beat.bz = bad_q ? '0 : er_q == 2'd0 ? u_q[2] : er_q == 2'd1 ? v_q[2] : w_q[2];
		beat.offset = bad_q ? '0 : off_q[er_q];
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			B_IDLE: if (job_valid) st_d = job.zero ? B_EMIT : B_PRE;
			B_PRE: st_d = mx == 64'd0 ? B_EMIT : B_SQ;
			B_SQ: st_d = B_SQRT;
			B_SQRT: if (bit_q == 64'd0) st_d = B_DIV;
			B_DIV: if (dstep_q == 7'd0 && ci_q == 2'd2) st_d = pass_q ? B_V : B_CROSS;
			B_CROSS: if (sel_q == 2'd1 && ci_q == 2'd2) st_d = B_PRE;
			B_V: if (sel_q == 2'd1 && ci_q == 2'd2) st_d = B_OFF;
			B_OFF: if (oi_q == 2'd3 && orow_q == 2'd2) st_d = B_EMIT;
			B_EMIT: if (out_ready && er_q == 2'd2) st_d = B_IDLE;
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: begin
				a_q[0] <= 64'(job.dx); a_q[1] <= 64'(job.dy); a_q[2] <= 64'(job.dz);
				p_q[0] <= job.px; p_q[1] <= job.py; p_q[2] <= job.pz;
				up_q[0] <= job.ux; up_q[1] <= job.uy; up_q[2] <= job.uz;
				bad_q <= job.zero; pass_q <= 1'b0; er_q <= 2'd0;
			end
			B_PRE: begin
				if (mx == 64'd0) bad_q <= 1'b1;
				for (int i = 0; i < 3; i++) s_q[i] <= 32'(sh[i]);
				if (!pass_q)
					for (int i = 0; i < 3; i++) up_q[i] <= 32'(ush[i]);
				ci_q <= 2'd0;
			end
			B_SQ: begin
				rem_q <= 64'(sq[0] + sq[1] + sq[2]);
				res_q <= '0; bit_q <= 64'd1 << 62;
			end
			B_SQRT: begin
				if (bit_q != 64'd0) begin
					if (rem_q >= res_q + bit_q) begin
						rem_q <= rem_q - (res_q + bit_q);
						res_q <= (res_q >> 1) + bit_q;
					end else res_q <= res_q >> 1;
					bit_q <= bit_q >> 2;
				end else begin
					n_q <= 32'(res_q);
					num_q <= (cur_mag << 30) + 64'(res_q[31:1]);
					quo_q <= '0; rem_q <= '0; dstep_q <= 7'd64;
				end
			end
			B_DIV: begin
				if (dstep_q != 7'd0) begin
					// restoring divide, one quotient bit per cycle
					if ({rem_q[62:0], num_q[63]} >= 64'(n_q)) begin
						rem_q <= {rem_q[62:0], num_q[63]} - 64'(n_q);
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= {rem_q[62:0], num_q[63]};
						quo_q <= {quo_q[62:0], 1'b0};
					end
					num_q <= num_q << 1;
					dstep_q <= dstep_q - 7'd1;
				end else begin
					if (pass_q) u_q[ci_q] <= s_q[ci_q][31] ? -32'(q_r) : 32'(q_r);
					else w_q[ci_q] <= s_q[ci_q][31] ? -32'(q_r) : 32'(q_r);
					ci_q <= ci_nx;
					num_q <= (mg(64'(s_q[ci_nx])) << 30) + 64'(n_q[31:1]);
					quo_q <= '0; rem_q <= '0; dstep_q <= 7'd64;
					sel_q <= 2'd0;
				end
			end
			B_CROSS, B_V: begin
				if (sel_q == 2'd0) begin
					cr_q <= mp; sel_q <= 2'd1;
				end else begin
					if (st_q == B_CROSS) a_q[ci_q] <= cr_q - mp;
					else v_q[ci_q] <= rv > 64'sd1073741824 ? 32'sd1073741824 :
						rv < -64'sd1073741824 ? -32'sd1073741824 : 32'(rv);
					sel_q <= 2'd0;
					ci_q <= ci_q == 2'd2 ? 2'd0 : ci_q + 2'd1;
					if (ci_q == 2'd2) pass_q <= 1'b1;
				end
				orow_q <= 2'd0; oi_q <= 2'd0; acc_q <= '0;
			end
			B_OFF: begin
				if (oi_q != 2'd3) begin
					acc_q <= acc_q + 96'(mp);
					oi_q <= oi_q + 2'd1;
				end else begin
					off_q[orow_q] <= rs > 96'sd2147483647 ? 32'sh7fffffff :
						rs < -96'sd2147483648 ? 32'sh80000000 : 32'(rs);
					acc_q <= '0; oi_q <= 2'd0; orow_q <= orow_q + 2'd1;
				end
			end
			B_EMIT: if (out_ready) er_q <= er_q + 2'd1;
			default: ;
		endcase
	end

	`include "assert_macros.svh"
	`ASSERT_IMPLIES(a_emit_row, clk, arst_n, out_valid, er_q != 2'd3)
	`ASSERT_NEXT(a_last_idle, clk, arst_n, out_valid && out_ready && er_q == 2'd2, st_q == B_IDLE)
	`ASSERT_IMPLIES(a_no_take, clk, arst_n, job_ready, !out_valid)
endmodule

@@ sv/look_at_view_matrix_core.sv @@
// Each item runs two square roots and six restoring divides in the back-end sequencer,
// which takes a new item only once all three row beats of the last one are out, and
// output stalls hold it; a degenerate direction or up vector finishes early.
// A two-entry queue decouples accept from compute. arst_n clears control state.
module look_at_view_matrix_core
	import lav_pkg::*;
#(
	parameter int COORD_FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic func,
	input logic signed [31:0] pos_x,
	input logic signed [31:0] pos_y,
	input logic signed [31:0] pos_z,
	input logic signed [31:0] look_x,
	input logic signed [31:0] look_y,
	input logic signed [31:0] look_z,
	input logic signed [31:0] up_x,
	input logic signed [31:0] up_y,
	input logic signed [31:0] up_z,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] row,
	output logic signed [31:0] basis_x,
	output logic signed [31:0] basis_y,
	output logic signed [31:0] basis_z,
	output logic signed [31:0] offset,
	output logic degenerate,
	output logic last
);
	logic job_valid, job_ready;
	job_t job;
	row_beat_t beat;

	lav_front u_front (.clk, .arst_n, .in_valid, .in_ready, .func, .pos_x, .pos_y, .pos_z,
		.look_x, .look_y, .look_z, .up_x, .up_y, .up_z, .job_valid, .job_ready, .job);
	lav_back u_back (.clk, .arst_n, .job_valid, .job_ready, .job, .out_valid, .out_ready,
		.beat);

	// offset format equals position format, so the fraction width needs no shift
	assign row = beat.row;
	assign basis_x = beat.bx;
	assign basis_y = beat.by;
	assign basis_z = beat.bz;
	assign offset = beat.offset;
	assign degenerate = beat.degenerate;
	assign last = beat.last;
endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the look-at view matrix core: directed, random and stall tests
module testbench;
	import lav_pkg::*;

	localparam longint BasisOne = 64'sd1 << 30;
	localparam longint BasisHalf = 64'sd1 << 29;
	localparam int unsigned CycleLimit = 1000000;
	localparam int unsigned HoldOffCycles = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic func = 1'b0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [31:0] look_x = '0, look_y = '0, look_z = '0;
	logic signed [31:0] up_x = '0, up_y = '0, up_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] row;
	logic signed [31:0] basis_x, basis_y, basis_z, offset;
	logic degenerate;
	logic last;

	row_beat_t expected_rows[$];
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit sender_idles = 1'b1;
	bit receiver_idles = 1'b1;
	bit hold_request = 1'b0;
	int unsigned hold_left = 0;

	look_at_view_matrix_core DUT (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(posedge clk) begin
		if (hold_request && hold_left == 0) begin
			hold_left <= HoldOffCycles;
			hold_request <= 1'b0;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= (hold_left == 1);
		end else begin
			out_ready <= !(receiver_idles && $urandom_range(0, 99) < 16);
		end
	end

	function automatic longint unsigned mag64(longint x);
		return x < 0 ? longint'(-x) : longint'(x);
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Bring the largest magnitude into [2^29, 2^30); zero vector fails.
	function automatic bit scale_vec(input longint a[3], output longint o[3]);
		longint unsigned m;
		longint f;
		int k;
		m = 0;
		for (int i = 0; i < 3; i++)
			if (mag64(a[i]) > m)
				m = mag64(a[i]);
		if (m == 0)
			return 1'b0;
		if (m >= BasisOne) begin
			k = 0;
			while ((m >> k) >= BasisOne)
				k++;
			for (int i = 0; i < 3; i++)
				o[i] = a[i] >>> k;
		end else begin
			f = 1;
			while (m < BasisHalf) begin
				m <<= 1;
				f *= 2;
			end
			for (int i = 0; i < 3; i++)
				o[i] = a[i] * f;
		end
		return 1'b1;
	endfunction

	function automatic bit unit_vec(input longint a[3], output longint o[3]);
		longint s[3];
		longint unsigned sum, n, q;
		if (!scale_vec(a, s))
			return 1'b0;
		sum = 0;
		for (int i = 0; i < 3; i++)
			sum += mag64(s[i]) * mag64(s[i]);
		n = floor_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = (mag64(s[i]) * BasisOne + n / 2) / n;
			if (q > BasisOne)
				q = BasisOne;
			o[i] = s[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1'b1;
	endfunction

	function automatic void cross3(input longint a[3], input longint b[3],
			output longint o[3]);
		o[0] = a[1] * b[2] - a[2] * b[1];
		o[1] = a[2] * b[0] - a[0] * b[2];
		o[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	// Work out the three rows for one item and queue them.
	function automatic void predict_view_rows(logic f, longint p[3], longint l[3],
			longint up[3]);
		longint d[3], ups[3], w[3], c[3], u[3], vx[3], rows[3][3];
		longint r, s;
		bit ok;
		row_beat_t beat;
		for (int i = 0; i < 3; i++)
			d[i] = f ? l[i] - p[i] : l[i];
		ok = unit_vec(d, w);
		if (ok)
			ok = scale_vec(up, ups);
		if (ok) begin
			cross3(w, ups, c);
			ok = unit_vec(c, u);
		end
		if (ok) begin
			cross3(w, u, vx);
			for (int i = 0; i < 3; i++) begin
				r = (vx[i] + BasisHalf) >>> 30;
				if (r > BasisOne) r = BasisOne;
				if (r < -BasisOne) r = -BasisOne;
				rows[0][i] = u[i];
				rows[1][i] = r;
				rows[2][i] = w[i];
			end
		end
		for (int k = 0; k < 3; k++) begin
			beat = '0;
			beat.row = k[1:0];
			beat.last = (k == 2);
			beat.degenerate = !ok;
			if (ok) begin
				beat.bx = rows[k][0][31:0];
				beat.by = rows[k][1][31:0];
				beat.bz = rows[k][2][31:0];
				s = -(rows[k][0] * p[0] + rows[k][1] * p[1] + rows[k][2] * p[2]);
				r = (s + BasisHalf) >>> 30;
				if (r > 64'sd2147483647) r = 64'sd2147483647;
				if (r < -64'sd2147483648) r = -64'sd2147483648;
				beat.offset = r[31:0];
			end
			expected_rows.push_back(beat);
		end
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			if (mismatches < 10)
				$display("mismatch %s: expected %h got %h", name, want, got);
			mismatches++;
		end
	endtask

	// Outputs settle after the rising edge, so judge the beat at the falling edge.
	always @(negedge clk) begin
		row_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_rows.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected row beat: row %0d", row);
				mismatches++;
			end else begin
				want = expected_rows.pop_front();
				check_field("row", want.row, row);
				check_field("basis_x", want.bx, basis_x);
				check_field("basis_y", want.by, basis_y);
				check_field("basis_z", want.bz, basis_z);
				check_field("offset", want.offset, offset);
				check_field("degenerate", want.degenerate, degenerate);
				check_field("last", want.last, last);
			end
		end
	end

	// Offer one item, hold it until accepted, then maybe idle.
	task automatic send_item(logic f, logic signed [31:0] p[3], logic signed [31:0] l[3],
			logic signed [31:0] up[3]);
		longint pl[3], ll[3], ul[3];
		for (int i = 0; i < 3; i++) begin
			pl[i] = p[i];
			ll[i] = l[i];
			ul[i] = up[i];
		end
		in_valid <= 1'b1;
		func <= f;
		pos_x <= p[0]; pos_y <= p[1]; pos_z <= p[2];
		look_x <= l[0]; look_y <= l[1]; look_z <= l[2];
		up_x <= up[0]; up_y <= up[1]; up_z <= up[2];
		forever begin
			@(negedge clk);
			if (in_ready)
				break;
		end
		predict_view_rows(f, pl, ll, ul);
		@(posedge clk);
		if (sender_idles && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] rand_coord(bit narrow);
		logic signed [31:0] v;
		v = $urandom;
		if (narrow)
			v = v >>> $urandom_range(0, 31);
		return v;
	endfunction

	task automatic send_random(bit target_mode);
		logic signed [31:0] p[3], l[3], up[3];
		bit narrow;
		narrow = $urandom_range(0, 1);
		for (int i = 0; i < 3; i++) begin
			p[i] = rand_coord(narrow);
			l[i] = rand_coord(narrow);
			up[i] = rand_coord($urandom_range(0, 1));
		end
		// Now and then make up parallel to the direction.
		if (!target_mode && $urandom_range(0, 19) == 0)
			for (int i = 0; i < 3; i++)
				up[i] = l[i] >>> $urandom_range(0, 3);
		send_item(target_mode ? 1'b1 : 1'b0, p, l, up);
	endtask

	task automatic test_directed;
		logic signed [31:0] z[3], one_y[3], fwd[3], mx[3], mn[3], ones[3];
		z = '{0, 0, 0};
		one_y = '{0, 32'sh10000, 0};
		fwd = '{0, 0, -32'sh10000};
		mx = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
		mn = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
		ones = '{1, 1, 1};
		send_item(1'b0, z, fwd, one_y);
		send_item(1'b1, '{32'sh30000, 0, 0}, z, one_y);
		send_item(1'b0, mx, mx, '{32'sh7fffffff, 32'sh80000000, 0});
		send_item(1'b0, mn, mn, '{0, 32'sh80000000, 32'sh7fffffff});
		send_item(1'b1, mn, mx, one_y);
		send_item(1'b1, mx, mn, '{32'sh80000000, 0, 0});
		send_item(1'b0, mx, ones, '{-1, 0, 0});
		send_item(1'b0, mn, '{32'sh7fffffff, 32'sh80000000, 1}, mx);
		send_item(1'b0, z, z, one_y);
		send_item(1'b1, mx, mx, one_y);
		send_item(1'b1, mn, mn, fwd);
		send_item(1'b0, z, fwd, z);
		send_item(1'b0, z, one_y, '{0, 5, 0});
		send_item(1'b0, mx, one_y, '{0, -32'sh7fffffff, 0});
		send_item(1'b0, z, mx, mn);
		send_item(1'b0, '{-1, -1, -1}, '{1, 0, 0}, '{0, 1, 0});
		send_item(1'b1, '{5, 7, -3}, '{5, 7, -3}, ones);
		send_item(1'b0, mn, '{32'sh12345678, -32'sh0abcdef0, 32'sh00fedcba}, ones);
	endtask

	task automatic test_random_direction(int n);
		repeat (n) send_random(1'b0);
	endtask

	task automatic test_random_target(int n);
		repeat (n) send_random(1'b1);
	endtask

	task automatic test_no_idle(int n);
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		repeat (n) send_random($urandom_range(0, 1));
		sender_idles = 1'b1;
		receiver_idles = 1'b1;
	endtask

	// Stall the output long enough that the input queue fills.
	task automatic test_output_hold_off(int n);
		hold_request = 1'b1;
		repeat (n) send_random($urandom_range(0, 1));
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_direction(200);
		test_no_idle(60);
		test_output_hold_off(10);
		test_random_target(200);
		test_random_direction(30);
		@(posedge clk);
		in_valid <= 1'b0;
		while (expected_rows.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

@@ look_at_view_matrix_core.f @@
+incdir+sv
sv/lav_pkg.sv
sv/lav_front.sv
sv/lav_back.sv
sv/look_at_view_matrix_core.sv
tb/testbench.sv
